// ----- sv/lpa_pkg.sv -----
// Package for the long-press alarm unit: phase, mode, event and status codes,
// configuration and result structs shared by the core and the top level.
// No dependencies.
package lpa_pkg;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_PRESSING   = 2'd1,
        PH_TRIGGERED  = 2'd2,
        PH_CANCELLING = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        MODE_POLL    = 2'd0,
        MODE_TRIGGER = 2'd1,
        MODE_CANCEL  = 2'd2,
        MODE_RESET   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_TRIGGERED = 3'd1,
        EV_TIMEOUT   = 3'd2,
        EV_SENT      = 3'd3,
        EV_CANCELLED = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_TRIGGERED = 2'd1,
        ST_WINDOW_CLOSED = 2'd2,
        ST_DISABLED      = 2'd3
    } status_t;

    localparam logic [1:0] REG_ENABLE         = 2'd0;
    localparam logic [1:0] REG_PRESS_DURATION = 2'd1;
    localparam logic [1:0] REG_CANCEL_WINDOW  = 2'd2;

    localparam logic        ENABLE_RESET         = 1'b1;
    localparam logic [15:0] PRESS_DURATION_RESET = 16'd3000;
    localparam logic [15:0] CANCEL_WINDOW_RESET  = 16'd10000;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic        enable;
        logic [15:0] press_duration_ms;
        logic [15:0] cancel_window_ms;
    } cfg_t;

    typedef struct packed {
        event_t  event_code;
        logic    send_alert;
        logic    send_cancel;
        logic    vibrate_short;
        logic    vibrate_alarm;
        logic    show_prompt;
        logic    alarm_active;
        phase_t  phase_now;
        status_t request_status;
    } result_t;

endpackage

// ----- sv/long_press_alarm_with_cancel_window_unit.sv -----
// Top level of the long-press alarm unit: stream ports, configuration
// registers, input and result registers. Depends on lpa_pkg and lpa_core.
//
// Each transaction on the input stream is one poll tick, manual trigger,
// cancel request or state reset, and yields exactly one result transaction.
// The unit accepts one transaction per clock while the output is not
// stalled; a result passes through the input register and then the result
// register, and the whole state update is done combinationally between the
// two, in the core. While a result waits on a
// stalled output, one more transaction can enter the input register; the
// input then stalls until the result leaves. Write configuration only while no
// transaction is in flight; cfg_ready is always high and writes to index 3
// are ignored.
module long_press_alarm_with_cancel_window_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] button_pressed, [32:1] now_ms, [39:33] zero
    input  logic [lpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] event_code, [3] send_alert, [4] send_cancel, [5] vibrate_short,
    // [6] vibrate_alarm, [7] show_prompt, [8] alarm_active, [10:9] phase_now,
    // [12:11] request_status, [15:13] zero
    output logic [lpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [15:0]                     cfg_data
);

    lpa_pkg::cfg_t    cfg_reg;
    lpa_pkg::result_t step_res;

    logic           in_valid_reg;
    lpa_pkg::mode_t in_mode_reg;
    logic           in_pressed_reg;
    logic [31:0]    in_now_reg;

    logic                            out_valid_reg;
    logic [lpa_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [lpa_pkg::OUT_TDATA_W-1:0] out_data_next;

    logic advance;
    logic in_take;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= lpa_pkg::ENABLE_RESET;
            cfg_reg.press_duration_ms <= lpa_pkg::PRESS_DURATION_RESET;
            cfg_reg.cancel_window_ms  <= lpa_pkg::CANCEL_WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lpa_pkg::REG_ENABLE:         cfg_reg.enable            <= cfg_data[0];
                lpa_pkg::REG_PRESS_DURATION: cfg_reg.press_duration_ms <= cfg_data;
                lpa_pkg::REG_CANCEL_WINDOW:  cfg_reg.cancel_window_ms  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg    <= lpa_pkg::mode_t'(s_axis_tuser);
            in_pressed_reg <= s_axis_tdata[0];
            in_now_reg     <= s_axis_tdata[32:1];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    lpa_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (advance),
        .mode           (in_mode_reg),
        .button_pressed (in_pressed_reg),
        .now_ms         (in_now_reg),
        .cfg            (cfg_reg),
        .res            (step_res)
    );

    assign out_data_next = {3'd0,
                            step_res.request_status,
                            step_res.phase_now,
                            step_res.alarm_active,
                            step_res.show_prompt,
                            step_res.vibrate_alarm,
                            step_res.vibrate_short,
                            step_res.send_cancel,
                            step_res.send_alert,
                            step_res.event_code};

endmodule

// ----- sv/lpa_core.sv -----
// Alarm state registers and the single-step update for one transaction.
// Depends on lpa_pkg.
module lpa_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  lpa_pkg::mode_t   mode,
    input  logic             button_pressed,
    input  logic [31:0]      now_ms,
    input  lpa_pkg::cfg_t    cfg,
    output lpa_pkg::result_t res
);

    lpa_pkg::phase_t phase_reg;
    lpa_pkg::phase_t phase_next;
    logic [31:0]     hold_origin_reg;
    logic [31:0]     hold_origin_next;
    logic [31:0]     trigger_time_reg;
    logic [31:0]     trigger_time_next;
    logic            alarm_flag_reg;
    logic            alarm_flag_next;
    logic            released_reg;
    logic            released_next;

    logic [31:0] press_elapsed;
    logic [31:0] trig_elapsed;
    logic        window_open;
    logic        hold_done;

    assign press_elapsed = now_ms - hold_origin_reg;
    assign trig_elapsed  = now_ms - trigger_time_reg;
    assign window_open   = trig_elapsed < {16'd0, cfg.cancel_window_ms};
    assign hold_done     = press_elapsed >= {16'd0, cfg.press_duration_ms};

    always_comb
    begin
        phase_next        = phase_reg;
        hold_origin_next  = hold_origin_reg;
        trigger_time_next = trigger_time_reg;
        alarm_flag_next   = alarm_flag_reg;
        released_next     = released_reg;

        res.event_code     = lpa_pkg::EV_NONE;
        res.send_alert     = 1'b0;
        res.send_cancel    = 1'b0;
        res.vibrate_short  = 1'b0;
        res.vibrate_alarm  = 1'b0;
        res.show_prompt    = 1'b0;
        res.request_status = lpa_pkg::ST_OK;

        case (mode)
            lpa_pkg::MODE_POLL:
            begin
                if (!cfg.enable)
                begin
                    res.request_status = lpa_pkg::ST_DISABLED;
                end
                else
                begin
                    case (phase_reg)
                        lpa_pkg::PH_IDLE:
                        begin
                            if (button_pressed)
                            begin
                                phase_next        = lpa_pkg::PH_PRESSING;
                                hold_origin_next  = now_ms;
                                res.vibrate_short = 1'b1;
                            end
                        end
                        lpa_pkg::PH_PRESSING:
                        begin
                            if (!button_pressed)
                            begin
                                phase_next = lpa_pkg::PH_IDLE;
                            end
                            else if (hold_done)
                            begin
                                phase_next        = lpa_pkg::PH_TRIGGERED;
                                alarm_flag_next   = 1'b1;
                                trigger_time_next = now_ms;
                                released_next     = 1'b0;
                                res.send_alert    = 1'b1;
                                res.vibrate_alarm = 1'b1;
                                res.event_code    = lpa_pkg::EV_TRIGGERED;
                            end
                        end
                        lpa_pkg::PH_TRIGGERED:
                        begin
                            if (!button_pressed)
                            begin
                                released_next = 1'b1;
                            end
                            if (window_open)
                            begin
                                phase_next      = lpa_pkg::PH_CANCELLING;
                                res.show_prompt = 1'b1;
                            end
                            else
                            begin
                                res.event_code  = lpa_pkg::EV_TIMEOUT;
                                phase_next      = lpa_pkg::PH_IDLE;
                                alarm_flag_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (!window_open)
                            begin
                                res.event_code  = lpa_pkg::EV_SENT;
                                phase_next      = lpa_pkg::PH_IDLE;
                                alarm_flag_next = 1'b0;
                            end
                            else if (button_pressed)
                            begin
                                if (released_reg && alarm_flag_reg)
                                begin
                                    phase_next      = lpa_pkg::PH_IDLE;
                                    alarm_flag_next = 1'b0;
                                    res.send_cancel = 1'b1;
                                    res.event_code  = lpa_pkg::EV_CANCELLED;
                                end
                            end
                            else
                            begin
                                released_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            lpa_pkg::MODE_TRIGGER:
            begin
                if (!cfg.enable)
                begin
                    res.request_status = lpa_pkg::ST_DISABLED;
                end
                else
                begin
                    phase_next        = lpa_pkg::PH_TRIGGERED;
                    alarm_flag_next   = 1'b1;
                    trigger_time_next = now_ms;
                    released_next     = 1'b0;
                    res.send_alert    = 1'b1;
                    res.vibrate_alarm = 1'b1;
                    res.event_code    = lpa_pkg::EV_TRIGGERED;
                end
            end
            lpa_pkg::MODE_CANCEL:
            begin
                if (!alarm_flag_reg)
                begin
                    res.request_status = lpa_pkg::ST_NOT_TRIGGERED;
                end
                else if (!window_open)
                begin
                    res.request_status = lpa_pkg::ST_WINDOW_CLOSED;
                end
                else
                begin
                    phase_next      = lpa_pkg::PH_IDLE;
                    alarm_flag_next = 1'b0;
                    res.send_cancel = 1'b1;
                    res.event_code  = lpa_pkg::EV_CANCELLED;
                end
            end
            default:
            begin
                phase_next        = lpa_pkg::PH_IDLE;
                hold_origin_next  = 32'd0;
                trigger_time_next = 32'd0;
                alarm_flag_next   = 1'b0;
                released_next     = 1'b0;
            end
        endcase

        res.alarm_active = alarm_flag_next;
        res.phase_now    = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lpa_pkg::PH_IDLE;
            hold_origin_reg  <= 32'd0;
            trigger_time_reg <= 32'd0;
            alarm_flag_reg   <= 1'b0;
            released_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg        <= phase_next;
            hold_origin_reg  <= hold_origin_next;
            trigger_time_reg <= trigger_time_next;
            alarm_flag_reg   <= alarm_flag_next;
            released_reg     <= released_next;
        end
    end

`ifndef ASSERT_OFF
    a_flag_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_flag_reg == (phase_reg == lpa_pkg::PH_TRIGGERED ||
                           phase_reg == lpa_pkg::PH_CANCELLING))
        else $error("alarm flag disagrees with phase");

    a_reset_mode_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && mode == lpa_pkg::MODE_RESET |=>
        phase_reg == lpa_pkg::PH_IDLE && !alarm_flag_reg && !released_reg)
        else $error("reset mode left state behind");

    a_alert_stamps_time: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.send_alert |=>
        trigger_time_reg == $past(now_ms) && !released_reg)
        else $error("trigger time not captured on alert");

    a_disabled_poll_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !cfg.enable && mode == lpa_pkg::MODE_POLL |=>
        $stable(phase_reg) && $stable(hold_origin_reg) && $stable(released_reg))
        else $error("disabled poll changed state");
`endif

endmodule

// ----- tb/sv/long_press_alarm_with_cancel_window_unit_tb.sv -----
// Testbench for long_press_alarm_with_cancel_window_unit: directed and random
// transactions, each result checked against an in-bench alarm state machine.
// Depends on lpa_pkg and the unit's RTL.
module long_press_alarm_with_cancel_window_unit_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 200;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = lpa_pkg::MODE_POLL;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [1:0]                      cfg_index = lpa_pkg::REG_ENABLE;
    logic [15:0]                     cfg_data = '0;

    lpa_pkg::cfg_t alarm_cfg = '{enable: lpa_pkg::ENABLE_RESET,
                                 press_duration_ms: lpa_pkg::PRESS_DURATION_RESET,
                                 cancel_window_ms: lpa_pkg::CANCEL_WINDOW_RESET};

    lpa_pkg::phase_t alarm_phase = lpa_pkg::PH_IDLE;
    logic [31:0]     hold_origin = '0;
    logic [31:0]     trigger_stamp = '0;
    logic            alarm_on = 1'b0;
    logic            released = 1'b0;

    lpa_pkg::result_t reports_due[$];
    lpa_pkg::result_t got;
    lpa_pkg::result_t want;
    int               mismatches = 0;
    int               send_idle_pct = 7;
    int               recv_stall_pct = 70;
    int               quiet_cycles = 0;
    logic [31:0]      clock_ms = '0;
    logic             held = 1'b0;

    long_press_alarm_with_cancel_window_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic lpa_pkg::result_t alarm_step(lpa_pkg::mode_t req, logic pressed,
                                                    logic [31:0] now);
        lpa_pkg::result_t r;
        logic             fire;
        logic             drop;
        logic             in_window;
        logic [31:0]      held_for;
        logic [31:0]      since_trigger;
        r = '0;
        r.event_code = lpa_pkg::EV_NONE;
        r.request_status = lpa_pkg::ST_OK;
        fire = 1'b0;
        drop = 1'b0;
        held_for = now - hold_origin;
        since_trigger = now - trigger_stamp;
        in_window = since_trigger < {16'd0, alarm_cfg.cancel_window_ms};
        case (req)
            lpa_pkg::MODE_POLL:
            begin
                if (!alarm_cfg.enable)
                    r.request_status = lpa_pkg::ST_DISABLED;
                else
                begin
                    case (alarm_phase)
                        lpa_pkg::PH_IDLE:
                        begin
                            if (pressed)
                            begin
                                alarm_phase = lpa_pkg::PH_PRESSING;
                                hold_origin = now;
                                r.vibrate_short = 1'b1;
                            end
                        end
                        lpa_pkg::PH_PRESSING:
                        begin
                            if (!pressed)
                                alarm_phase = lpa_pkg::PH_IDLE;
                            else if (held_for >= {16'd0, alarm_cfg.press_duration_ms})
                                fire = 1'b1;
                        end
                        lpa_pkg::PH_TRIGGERED:
                        begin
                            if (!pressed)
                                released = 1'b1;
                            if (in_window)
                            begin
                                alarm_phase = lpa_pkg::PH_CANCELLING;
                                r.show_prompt = 1'b1;
                            end
                            else
                            begin
                                r.event_code = lpa_pkg::EV_TIMEOUT;
                                alarm_phase = lpa_pkg::PH_IDLE;
                                alarm_on = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (!in_window)
                            begin
                                r.event_code = lpa_pkg::EV_SENT;
                                alarm_phase = lpa_pkg::PH_IDLE;
                                alarm_on = 1'b0;
                            end
                            else if (pressed)
                                drop = released && alarm_on;
                            else
                                released = 1'b1;
                        end
                    endcase
                end
            end
            lpa_pkg::MODE_TRIGGER:
            begin
                if (alarm_cfg.enable)
                    fire = 1'b1;
                else
                    r.request_status = lpa_pkg::ST_DISABLED;
            end
            lpa_pkg::MODE_CANCEL:
            begin
                if (!alarm_on)
                    r.request_status = lpa_pkg::ST_NOT_TRIGGERED;
                else if (!in_window)
                    r.request_status = lpa_pkg::ST_WINDOW_CLOSED;
                else
                    drop = 1'b1;
            end
            default:
            begin
                alarm_phase = lpa_pkg::PH_IDLE;
                hold_origin = '0;
                trigger_stamp = '0;
                alarm_on = 1'b0;
                released = 1'b0;
            end
        endcase
        if (fire)
        begin
            alarm_phase = lpa_pkg::PH_TRIGGERED;
            alarm_on = 1'b1;
            trigger_stamp = now;
            released = 1'b0;
            r.send_alert = 1'b1;
            r.vibrate_alarm = 1'b1;
            r.event_code = lpa_pkg::EV_TRIGGERED;
        end
        if (drop)
        begin
            alarm_phase = lpa_pkg::PH_IDLE;
            alarm_on = 1'b0;
            r.send_cancel = 1'b1;
            r.event_code = lpa_pkg::EV_CANCELLED;
        end
        r.alarm_active = alarm_on;
        r.phase_now = alarm_phase;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, seen, wanted);
    endtask

    task automatic issue_request(lpa_pkg::mode_t req, logic pressed, logic [31:0] now);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'd0, now, pressed};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        reports_due.push_back(alarm_step(req, pressed, now));
    endtask

    // drop valid, drain all pending results, then hold past the pipeline
    task automatic settle;
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            lpa_pkg::REG_ENABLE:         alarm_cfg.enable = value[0];
            lpa_pkg::REG_PRESS_DURATION: alarm_cfg.press_duration_ms = value;
            lpa_pkg::REG_CANCEL_WINDOW:  alarm_cfg.cancel_window_ms = value;
            default:                     ;
        endcase
    endtask

    task automatic load_settings(logic en, logic [15:0] dur, logic [15:0] win);
        settle();
        write_register(lpa_pkg::REG_ENABLE, {15'd0, en});
        write_register(lpa_pkg::REG_PRESS_DURATION, dur);
        write_register(lpa_pkg::REG_CANCEL_WINDOW, win);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_hold_and_cancel;
        issue_request(lpa_pkg::MODE_POLL, 1'b0, 32'd0);
        issue_request(lpa_pkg::MODE_POLL, 1'b1, 32'd100);
        issue_request(lpa_pkg::MODE_POLL, 1'b1, 32'd3099);
        issue_request(lpa_pkg::MODE_POLL, 1'b1, 32'd3100);
        issue_request(lpa_pkg::MODE_POLL, 1'b1, 32'd3200);
        issue_request(lpa_pkg::MODE_POLL, 1'b1, 32'd3300);
        issue_request(lpa_pkg::MODE_POLL, 1'b0, 32'd3400);
        issue_request(lpa_pkg::MODE_POLL, 1'b1, 32'd3500);
        issue_request(lpa_pkg::MODE_POLL, 1'b0, 32'd3600);
    endtask

    task automatic test_window_expiry;
        issue_request(lpa_pkg::MODE_TRIGGER, 1'b0, 32'hFFFF_FF00);
        issue_request(lpa_pkg::MODE_POLL, 1'b0, 32'h0000_0100);
        issue_request(lpa_pkg::MODE_POLL, 1'b1, 32'hFFFF_FF00 + 32'd10000);
        issue_request(lpa_pkg::MODE_TRIGGER, 1'b1, 32'hFFFF_FFFF);
        issue_request(lpa_pkg::MODE_POLL, 1'b1, 32'hFFFF_FFFF + 32'd10000);
    endtask

    task automatic test_requests;
        issue_request(lpa_pkg::MODE_CANCEL, 1'b0, 32'd0);
        issue_request(lpa_pkg::MODE_TRIGGER, 1'b0, 32'd1000);
        issue_request(lpa_pkg::MODE_CANCEL, 1'b1, 32'd11000);
        issue_request(lpa_pkg::MODE_CANCEL, 1'b0, 32'd10999);
        issue_request(lpa_pkg::MODE_TRIGGER, 1'b1, 32'd5000);
        issue_request(lpa_pkg::MODE_POLL, 1'b0, 32'd5001);
        issue_request(lpa_pkg::MODE_RESET, 1'b1, 32'd7);
    endtask

    task automatic test_disabled;
        issue_request(lpa_pkg::MODE_TRIGGER, 1'b0, 32'd200);
        load_settings(1'b0, lpa_pkg::PRESS_DURATION_RESET, lpa_pkg::CANCEL_WINDOW_RESET);
        issue_request(lpa_pkg::MODE_POLL, 1'b1, 32'd300);
        issue_request(lpa_pkg::MODE_TRIGGER, 1'b1, 32'd400);
        issue_request(lpa_pkg::MODE_CANCEL, 1'b0, 32'd500);
        issue_request(lpa_pkg::MODE_POLL, 1'b0, 32'hFFFF_FFFF);
        issue_request(lpa_pkg::MODE_RESET, 1'b0, 32'd0);
    endtask

    task automatic test_random_traffic(int items, logic en, logic [15:0] dur,
                                       logic [15:0] win);
        int span;
        int pick;
        load_settings(en, dur, win);
        span = int'((dur > win) ? dur : win);
        clock_ms = $urandom;
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 25)
                held = !held;
            if ($urandom_range(0, 99) < 2)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, span / 3 + 2);
            if (pick < 3)
                issue_request(lpa_pkg::MODE_RESET, 1'($urandom_range(0, 1)), clock_ms);
            else if (pick < 11)
                issue_request(lpa_pkg::MODE_CANCEL, 1'($urandom_range(0, 1)), clock_ms);
            else if (pick < 19)
                issue_request(lpa_pkg::MODE_TRIGGER, 1'($urandom_range(0, 1)), clock_ms);
            else
                issue_request(lpa_pkg::MODE_POLL, held, clock_ms);
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.event_code     = lpa_pkg::event_t'(m_axis_tdata[2:0]);
            got.send_alert     = m_axis_tdata[3];
            got.send_cancel    = m_axis_tdata[4];
            got.vibrate_short  = m_axis_tdata[5];
            got.vibrate_alarm  = m_axis_tdata[6];
            got.show_prompt    = m_axis_tdata[7];
            got.alarm_active   = m_axis_tdata[8];
            got.phase_now      = lpa_pkg::phase_t'(m_axis_tdata[10:9]);
            got.request_status = lpa_pkg::status_t'(m_axis_tdata[12:11]);
            if (reports_due.size() == 0)
                flag_mismatch("unexpected result", 32'(m_axis_tdata), 32'd0);
            else
            begin
                want = reports_due.pop_front();
                if (got.event_code !== want.event_code)
                    flag_mismatch("event_code", 32'(got.event_code),
                                  32'(want.event_code));
                if (got.send_alert !== want.send_alert)
                    flag_mismatch("send_alert", 32'(got.send_alert),
                                  32'(want.send_alert));
                if (got.send_cancel !== want.send_cancel)
                    flag_mismatch("send_cancel", 32'(got.send_cancel),
                                  32'(want.send_cancel));
                if (got.vibrate_short !== want.vibrate_short)
                    flag_mismatch("vibrate_short", 32'(got.vibrate_short),
                                  32'(want.vibrate_short));
                if (got.vibrate_alarm !== want.vibrate_alarm)
                    flag_mismatch("vibrate_alarm", 32'(got.vibrate_alarm),
                                  32'(want.vibrate_alarm));
                if (got.show_prompt !== want.show_prompt)
                    flag_mismatch("show_prompt", 32'(got.show_prompt),
                                  32'(want.show_prompt));
                if (got.alarm_active !== want.alarm_active)
                    flag_mismatch("alarm_active", 32'(got.alarm_active),
                                  32'(want.alarm_active));
                if (got.phase_now !== want.phase_now)
                    flag_mismatch("phase_now", 32'(got.phase_now),
                                  32'(want.phase_now));
                if (got.request_status !== want.request_status)
                    flag_mismatch("request_status", 32'(got.request_status),
                                  32'(want.request_status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_stall_pct = 70;
        test_hold_and_cancel();
        test_window_expiry();
        test_requests();
        test_disabled();
        test_random_traffic(300, 1'b1, 16'd1, 16'd1);
        test_random_traffic(300, 1'b1, 16'd65535, 16'd65535);

        send_idle_pct = 70;
        recv_stall_pct = 7;
        test_random_traffic(300, 1'b1, 16'($urandom_range(1, 40)),
                            16'($urandom_range(1, 80)));
        test_random_traffic(100, 1'b0, 16'($urandom_range(1, 40)),
                            16'($urandom_range(1, 80)));
        test_random_traffic(150, 1'b1, 16'd65535, 16'd1);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(150, 1'b1, 16'd1, 16'd65535);
        test_random_traffic(300, 1'b1, 16'($urandom_range(1, 2000)),
                            16'($urandom_range(1, 4000)));
        test_random_traffic(300, 1'b1, lpa_pkg::PRESS_DURATION_RESET,
                            lpa_pkg::CANCEL_WINDOW_RESET);

        settle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
